// ===== sv/serial_led_command_parser_assert.svh =====
// Assertion macros for the serial LED command parser.
// Used by the top level only; no other dependencies.
`ifndef SERIAL_LED_COMMAND_PARSER_ASSERT_SVH
`define SERIAL_LED_COMMAND_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SLCP_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("slcp same-cycle check failed");
`define SLCP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("slcp next-cycle check failed");
`else
`define SLCP_ASSERT_SAME(label, pre, post)
`define SLCP_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ===== sv/slcp_pkg.sv =====
// Shared types, codes and reply text table for the serial LED command parser.
// No dependencies.
package slcp_pkg;

    localparam logic [7:0] CH_EOL  = 8'h0D;
    localparam logic [7:0] CH_ESC  = 8'h2B;
    localparam logic [7:0] CH_ID   = 8'h3F;   // '?'
    localparam logic [7:0] CH_SYNC = 8'h21;   // '!'
    localparam logic [7:0] CH_LED  = 8'h6C;   // 'l'

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_APPEND = 2'd2;
    localparam logic [1:0] KIND_SHOW   = 2'd3;

    typedef enum logic [2:0] {
        PS_IDLE      = 3'd0,
        PS_WAIT_ID   = 3'd1,
        PS_WAIT_SYNC = 3'd2,
        PS_WAIT_ERR  = 3'd3,
        PS_DATA      = 3'd4,
        PS_DATA_ESC  = 3'd5
    } slcp_parse_t;

    typedef enum logic {
        BS_IDLE = 1'b0,
        BS_TEXT = 1'b1
    } slcp_back_t;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_SHOW   = 3'd2,
        OP_ID     = 3'd3,
        OP_SYNC   = 3'd4,
        OP_ERR    = 3'd5
    } slcp_op_t;

    typedef struct packed {
        slcp_op_t   op;
        logic [7:0] data;
    } slcp_cmd_t;

    typedef struct packed {
        logic      valid;
        slcp_cmd_t cmd;
    } slcp_push_t;

    // reply text: identify, sync, OK, ERROR, back to back
    localparam int MSG_LEN = 46;
    localparam int MSG_AW  = $clog2(MSG_LEN);

    localparam logic [MSG_AW-1:0] ID_BASE   = MSG_AW'(0);
    localparam logic [MSG_AW-1:0] ID_END    = MSG_AW'(28);
    localparam logic [MSG_AW-1:0] SYNC_BASE = MSG_AW'(29);
    localparam logic [MSG_AW-1:0] SYNC_END  = MSG_AW'(36);
    localparam logic [MSG_AW-1:0] OK_BASE   = MSG_AW'(37);
    localparam logic [MSG_AW-1:0] OK_END    = MSG_AW'(39);
    localparam logic [MSG_AW-1:0] ERR_BASE  = MSG_AW'(40);
    localparam logic [MSG_AW-1:0] ERR_END   = MSG_AW'(45);

    function automatic logic [7:0] msg_byte(input logic [MSG_AW-1:0] addr);
        logic [7:0] b;
        case (addr)
            // identify reply
            6'd0:  b = 8'h4F;
            6'd1:  b = 8'h4B;
            6'd2:  b = 8'h20;
            6'd3:  b = 8'h73;
            6'd4:  b = 8'h65;
            6'd5:  b = 8'h72;
            6'd6:  b = 8'h32;
            6'd7:  b = 8'h6E;
            6'd8:  b = 8'h65;
            6'd9:  b = 8'h6F;
            6'd10: b = 8'h20;
            6'd11: b = 8'h31;
            6'd12: b = 8'h20;
            6'd13: b = 8'h6E;
            6'd14: b = 8'h65;
            6'd15: b = 8'h6F;
            6'd16: b = 8'h70;
            6'd17: b = 8'h69;
            6'd18: b = 8'h78;
            6'd19: b = 8'h65;
            6'd20: b = 8'h6C;
            6'd21: b = 8'h20;
            6'd22: b = 8'h31;
            6'd23: b = 8'h36;
            6'd24: b = 8'h20;
            6'd25: b = 8'h67;
            6'd26: b = 8'h72;
            6'd27: b = 8'h62;
            6'd28: b = 8'h0A;
            // sync reply
            6'd29: b = 8'h4F;
            6'd30: b = 8'h4B;
            6'd31: b = 8'h20;
            6'd32: b = 8'h73;
            6'd33: b = 8'h79;
            6'd34: b = 8'h6E;
            6'd35: b = 8'h63;
            6'd36: b = 8'h0A;
            // OK
            6'd37: b = 8'h4F;
            6'd38: b = 8'h4B;
            6'd39: b = 8'h0A;
            // ERROR
            6'd40: b = 8'h45;
            6'd41: b = 8'h52;
            6'd42: b = 8'h52;
            6'd43: b = 8'h4F;
            6'd44: b = 8'h52;
            6'd45: b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/serial_led_command_parser.sv =====
// Serial LED command parser. A command is registered in the queue, then each
// result in the single output register. Output: one result per cycle while
// m_ready is high; a byte has at most 29 results (the identify reply).
// Input: one byte per cycle while the 4-entry command queue has room.
// Reset (aresetn low, synchronous) returns the parser to idle and empties
// the queue and output stage.
`include "serial_led_command_parser_assert.svh"

module serial_led_command_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data,
    output logic       m_last
);
    import slcp_pkg::*;

    slcp_push_t push;
    slcp_cmd_t  head;
    logic       q_full;
    logic       head_valid;
    logic       pop;

    slcp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .push      (push)
    );

    slcp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    slcp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_data     (m_data),
        .m_last     (m_last)
    );

    // single-result events always close their transaction group
    `SLCP_ASSERT_SAME(a_clear_last, m_valid && m_kind == KIND_CLEAR, m_last)
    `SLCP_ASSERT_SAME(a_append_last, m_valid && m_kind == KIND_APPEND, m_last)
    // show is always followed by the OK text
    `SLCP_ASSERT_SAME(a_show_not_last, m_valid && m_kind == KIND_SHOW, !m_last)
    `SLCP_ASSERT_NEXT(a_show_then_tx, m_valid && m_ready && m_kind == KIND_SHOW,
                      !m_valid || m_kind == KIND_TX)

endmodule

// ===== sv/slcp_front.sv =====
// Line parser: accepts rx bytes, tracks the parse state and issues one
// command per byte that causes results. Depends on slcp_pkg.
module slcp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    input  logic                q_full,
    output slcp_pkg::slcp_push_t push
);
    import slcp_pkg::*;

    slcp_parse_t state_reg, state_next;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        if (accept) begin
            unique case (state_reg)
                PS_WAIT_ID, PS_WAIT_SYNC, PS_WAIT_ERR: begin
                    if (s_rx_byte == CH_EOL) state_next = PS_IDLE;
                end
                PS_DATA, PS_DATA_ESC: begin
                    if (s_rx_byte == CH_EOL)        state_next = PS_IDLE;
                    else if (state_reg == PS_DATA_ESC) state_next = PS_DATA;
                    else if (s_rx_byte == CH_ESC)   state_next = PS_DATA_ESC;
                end
                default: begin
                    if (s_rx_byte == CH_ID)        state_next = PS_WAIT_ID;
                    else if (s_rx_byte == CH_SYNC) state_next = PS_WAIT_SYNC;
                    else if (s_rx_byte == CH_LED)  state_next = PS_DATA;
                    else if (s_rx_byte == CH_EOL)  state_next = PS_IDLE;
                    else                           state_next = PS_WAIT_ERR;
                end
            endcase
        end
    end

    always_comb begin
        push.valid    = 1'b0;
        push.cmd.op   = OP_APPEND;
        push.cmd.data = s_rx_byte;
        unique case (state_reg)
            PS_WAIT_ID, PS_WAIT_SYNC, PS_WAIT_ERR: begin
                if (s_rx_byte == CH_EOL) begin
                    push.valid  = accept;
                    push.cmd.op = (state_reg == PS_WAIT_ID)   ? OP_ID :
                                  (state_reg == PS_WAIT_SYNC) ? OP_SYNC : OP_ERR;
                end
            end
            PS_DATA, PS_DATA_ESC: begin
                if (s_rx_byte == CH_EOL) begin
                    push.valid  = accept;
                    push.cmd.op = OP_SHOW;
                end else if (state_reg == PS_DATA_ESC) begin
                    push.valid    = accept;
                    push.cmd.data = s_rx_byte ^ CH_ESC;
                end else if (s_rx_byte != CH_ESC) begin
                    push.valid = accept;
                end
            end
            default: begin
                if (s_rx_byte == CH_LED) begin
                    push.valid  = accept;
                    push.cmd.op = OP_CLEAR;
                end
            end
        endcase
    end

endmodule

// ===== sv/slcp_queue.sv =====
// Short command queue between parser and output sequencer.
// Depends on slcp_pkg.
module slcp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  slcp_pkg::slcp_push_t push,
    output logic                 full,
    output logic                 head_valid,
    output slcp_pkg::slcp_cmd_t  head,
    input  logic                 pop
);
    import slcp_pkg::*;

    slcp_cmd_t         entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop)      count_next = count_reg + 1'b1;
        else if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push.cmd;
    end

endmodule

// ===== sv/slcp_back.sv =====
// Output sequencer: expands queued commands into result items through a
// registered output stage. Depends on slcp_pkg (reply text table).
module slcp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  slcp_pkg::slcp_cmd_t head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [7:0]          m_data,
    output logic                m_last
);
    import slcp_pkg::*;

    slcp_back_t        state_reg, state_next;
    logic [MSG_AW-1:0] ptr_reg, ptr_next;
    logic [MSG_AW-1:0] end_reg, end_next;
    logic              valid_reg, valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [7:0]        data_reg, data_next;
    logic              last_reg, last_next;
    logic              slot_free;
    logic              load;

    assign slot_free = !valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE: begin
                if (slot_free && head_valid &&
                    (head.op == OP_SHOW || head.op == OP_ID ||
                     head.op == OP_SYNC || head.op == OP_ERR)) begin
                    state_next = BS_TEXT;
                end
            end
            BS_TEXT: begin
                if (slot_free && ptr_reg == end_reg) state_next = BS_IDLE;
            end
            default: state_next = BS_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        load      = 1'b0;
        ptr_next  = ptr_reg;
        end_next  = end_reg;
        kind_next = KIND_TX;
        data_next = 8'h00;
        last_next = 1'b0;
        unique case (state_reg)
            BS_IDLE: begin
                if (slot_free && head_valid) begin
                    pop  = 1'b1;
                    load = 1'b1;
                    unique case (head.op)
                        OP_CLEAR: begin
                            kind_next = KIND_CLEAR;
                            last_next = 1'b1;
                        end
                        OP_APPEND: begin
                            kind_next = KIND_APPEND;
                            data_next = head.data;
                            last_next = 1'b1;
                        end
                        OP_SHOW: begin
                            kind_next = KIND_SHOW;
                            ptr_next  = OK_BASE;
                            end_next  = OK_END;
                        end
                        OP_ID: begin
                            data_next = msg_byte(ID_BASE);
                            ptr_next  = ID_BASE + MSG_AW'(1);
                            end_next  = ID_END;
                        end
                        OP_SYNC: begin
                            data_next = msg_byte(SYNC_BASE);
                            ptr_next  = SYNC_BASE + MSG_AW'(1);
                            end_next  = SYNC_END;
                        end
                        default: begin
                            data_next = msg_byte(ERR_BASE);
                            ptr_next  = ERR_BASE + MSG_AW'(1);
                            end_next  = ERR_END;
                        end
                    endcase
                end
            end
            BS_TEXT: begin
                if (slot_free) begin
                    load      = 1'b1;
                    data_next = msg_byte(ptr_reg);
                    last_next = (ptr_reg == end_reg);
                    ptr_next  = ptr_reg + MSG_AW'(1);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (load)          valid_next = 1'b1;
        else if (m_ready)  valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BS_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        end_reg <= end_next;
        if (load) begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            last_reg <= last_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_kind  = kind_reg;
    assign m_data  = data_reg;
    assign m_last  = last_reg;

endmodule

// ===== tb/sv/tb_serial_led_command_parser.sv =====
// Testbench for serial_led_command_parser: directed table, then random command lines.
// Depends on slcp_pkg and the parser RTL; results are checked against a local line-parser model.
`timescale 1ns / 100ps

module tb_serial_led_command_parser;
    import slcp_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } led_result_t;

    typedef enum logic [1:0] {
        ROW_PRED = 2'd0,   // expectation from the parser model
        ROW_NONE = 2'd1,   // typed: no result
        ROW_ONE  = 2'd2    // typed: exactly one result
    } row_check_t;

    typedef struct packed {
        logic [7:0] rx;
        row_check_t check;
        logic [1:0] kind;
        logic [7:0] data;
    } rx_row_t;

    localparam int DIR_ROWS = 24;
    localparam int ID_LEN   = 29;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_kind;
    logic [7:0] m_data;
    logic       m_last;

    serial_led_command_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_data    (m_data),
        .m_last    (m_last)
    );

    // identify reply text, byte by byte
    logic [7:0] id_reply [ID_LEN] = '{
        8'h4F, 8'h4B, 8'h20, 8'h73, 8'h65, 8'h72, 8'h32, 8'h6E, 8'h65, 8'h6F,
        8'h20, 8'h31, 8'h20, 8'h6E, 8'h65, 8'h6F, 8'h70, 8'h69, 8'h78, 8'h65,
        8'h6C, 8'h20, 8'h31, 8'h36, 8'h20, 8'h67, 8'h72, 8'h62, 8'h0A
    };

    rx_row_t dir_rows [DIR_ROWS] = '{
        '{CH_EOL,  ROW_NONE, KIND_TX,     8'h00},  // lone return
        '{CH_ID,   ROW_NONE, KIND_TX,     8'h00},
        '{8'h00,   ROW_NONE, KIND_TX,     8'h00},
        '{8'hFF,   ROW_NONE, KIND_TX,     8'h00},
        '{CH_EOL,  ROW_PRED, KIND_TX,     8'h00},  // identify reply
        '{CH_SYNC, ROW_NONE, KIND_TX,     8'h00},
        '{CH_EOL,  ROW_PRED, KIND_TX,     8'h00},  // sync reply
        '{CH_LED,  ROW_ONE,  KIND_CLEAR,  8'h00},
        '{8'h00,   ROW_ONE,  KIND_APPEND, 8'h00},
        '{8'hFF,   ROW_ONE,  KIND_APPEND, 8'hFF},
        '{CH_ESC,  ROW_NONE, KIND_TX,     8'h00},
        '{CH_ESC,  ROW_ONE,  KIND_APPEND, 8'h00},  // escaped escape
        '{CH_ESC,  ROW_NONE, KIND_TX,     8'h00},
        '{8'hD4,   ROW_ONE,  KIND_APPEND, 8'hFF},
        '{CH_ID,   ROW_ONE,  KIND_APPEND, 8'h3F},  // command char as level
        '{CH_ESC,  ROW_NONE, KIND_TX,     8'h00},
        '{CH_EOL,  ROW_PRED, KIND_TX,     8'h00},  // return right after escape
        '{8'h00,   ROW_NONE, KIND_TX,     8'h00},
        '{CH_LED,  ROW_NONE, KIND_TX,     8'h00},
        '{CH_EOL,  ROW_PRED, KIND_TX,     8'h00},  // ERROR
        '{8'hFF,   ROW_NONE, KIND_TX,     8'h00},
        '{CH_EOL,  ROW_PRED, KIND_TX,     8'h00},
        '{CH_LED,  ROW_ONE,  KIND_CLEAR,  8'h00},
        '{CH_EOL,  ROW_PRED, KIND_TX,     8'h00}   // empty LED line
    };

    slcp_parse_t parse_st;
    led_result_t step_results [$];
    led_result_t exp_results [$];
    int          mismatch_count = 0;
    int          rx_count = 0;
    int          result_count = 0;
    bit          tx_burst = 0;
    bit          rx_burst = 0;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic add_result(input logic [1:0] kind, input logic [7:0] data);
        led_result_t r;
        r.kind = kind;
        r.data = data;
        r.last = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_result(KIND_TX, s[i]);
    endtask

    // line parser: results of one rx byte go to step_results
    task automatic predict_rx(input logic [7:0] b);
        int i;
        step_results.delete();
        case (parse_st)
            PS_WAIT_ID, PS_WAIT_SYNC, PS_WAIT_ERR: begin
                if (b == CH_EOL) begin
                    if (parse_st == PS_WAIT_ID) begin
                        for (i = 0; i < ID_LEN; i++)
                            add_result(KIND_TX, id_reply[i]);
                    end else if (parse_st == PS_WAIT_SYNC) begin
                        add_text("OK sync\n");
                    end else begin
                        add_text("ERROR\n");
                    end
                    parse_st = PS_IDLE;
                end
            end
            PS_DATA, PS_DATA_ESC: begin
                if (b == CH_EOL) begin
                    add_result(KIND_SHOW, 8'h00);
                    add_text("OK\n");
                    parse_st = PS_IDLE;
                end else if (parse_st == PS_DATA_ESC) begin
                    add_result(KIND_APPEND, b ^ CH_ESC);
                    parse_st = PS_DATA;
                end else if (b == CH_ESC) begin
                    parse_st = PS_DATA_ESC;
                end else begin
                    add_result(KIND_APPEND, b);
                end
            end
            default: begin
                if (b == CH_ID)
                    parse_st = PS_WAIT_ID;
                else if (b == CH_SYNC)
                    parse_st = PS_WAIT_SYNC;
                else if (b == CH_LED) begin
                    add_result(KIND_CLEAR, 8'h00);
                    parse_st = PS_DATA;
                end else if (b == CH_EOL)
                    parse_st = PS_IDLE;
                else
                    parse_st = PS_WAIT_ERR;
            end
        endcase
    endtask

    task automatic commit_step();
        int i;
        led_result_t r;
        for (i = 0; i < step_results.size(); i++) begin
            r = step_results[i];
            r.last = (i == step_results.size() - 1);
            exp_results.push_back(r);
        end
    endtask

    function automatic int sender_gap();
        int r;
        if (tx_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    function automatic logic [7:0] rand_fill();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_EOL)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic send_rx(input logic [7:0] b);
        int gap;
        gap = sender_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        rx_count++;
    endtask

    task automatic emit(input logic [7:0] b);
        send_rx(b);
        predict_rx(b);
        commit_step();
    endtask

    // lower valid, then hold off until every expected result has been seen or max_cycles have passed
    task automatic drain_results(input int max_cycles);
        int n;
        n = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (exp_results.size() != 0 && n < max_cycles) begin
            @(posedge aclk);
            n++;
        end
        if (exp_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      exp_results.size()));
    endtask

    // result side: random stalls, some long, with stall-free stretches
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 199) == 0)
                rx_burst = !rx_burst;
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (rx_burst) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    stall_left = $urandom_range(10, 40);
                    m_ready <= 1'b0;
                end else if (r < 20) begin
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_check
        led_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            result_count++;
            if (exp_results.size() == 0) begin
                report_mismatch($sformatf("result %0d unexpected: kind=%0d data=%02h last=%0b",
                                          result_count, m_kind, m_data, m_last));
            end else begin
                want = exp_results.pop_front();
                if (m_kind !== want.kind)
                    report_mismatch($sformatf("result %0d kind=%0d, want %0d",
                                              result_count, m_kind, want.kind));
                if (m_data !== want.data)
                    report_mismatch($sformatf("result %0d data=%02h, want %02h",
                                              result_count, m_data, want.data));
                if (m_last !== want.last)
                    report_mismatch($sformatf("result %0d last=%0b, want %0b",
                                              result_count, m_last, want.last));
            end
        end
    end

    initial begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int          i;
        int          n;
        int          pick;
        rx_row_t     row;
        led_result_t r;
        logic [7:0]  cmd;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = 8'h00;
        parse_st  = PS_IDLE;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            row = dir_rows[i];
            send_rx(row.rx);
            predict_rx(row.rx);
            case (row.check)
                ROW_PRED: commit_step();
                ROW_ONE: begin
                    r.kind = row.kind;
                    r.data = row.data;
                    r.last = 1'b1;
                    exp_results.push_back(r);
                end
                default: ;
            endcase
        end
        drain_results(20000);

        while (rx_count < DIR_ROWS + 450) begin
            if ($urandom_range(0, 9) == 0)
                tx_burst = !tx_burst;
            if ($urandom_range(0, 39) == 0)
                drain_results(20000);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                emit(CH_LED);
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 10);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        emit(CH_ESC);
                        emit(rand_fill());
                    end else begin
                        emit(rand_fill());
                    end
                end
                if ($urandom_range(0, 7) == 0)
                    emit(CH_ESC);
                emit(CH_EOL);
            end else if (pick < 65) begin
                emit(pick < 55 ? CH_ID : CH_SYNC);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    emit(rand_fill());
                emit(CH_EOL);
            end else if (pick < 77) begin
                cmd = rand_fill();
                while (cmd == CH_ID || cmd == CH_SYNC || cmd == CH_LED)
                    cmd = rand_fill();
                emit(cmd);
                n = $urandom_range(0, 5);
                for (i = 0; i < n; i++)
                    emit(rand_fill());
                emit(CH_EOL);
            end else if (pick < 82) begin
                emit(CH_EOL);
            end else begin
                // noise: arbitrary bytes, broken lines included
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    emit(($urandom_range(0, 3) == 0) ? CH_EOL : 8'($urandom_range(0, 255)));
            end
        end

        drain_results(50000);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/slcp_pkg.sv
sv/slcp_front.sv
sv/slcp_queue.sv
sv/slcp_back.sv
sv/serial_led_command_parser.sv
tb/sv/tb_serial_led_command_parser.sv
